// ----- rtl/core/pstc_pkg.sv -----
// Shared constants, codes and control types for the point slot table with centroid.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pstc_pkg;

  // Table and coordinate sizes
  localparam int SLOTS    = 128;
  localparam int COORD_W  = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SUM_W    = COORD_W + SLOT_W;

  // Fixed port widths of the item fields
  localparam int IDX_W    = 7;
  localparam int OCC_W    = 8;

  // Free-slot search: groups of eight valid bits
  localparam int GRP_SIZE = 8;
  localparam int BIT_W    = $clog2(GRP_SIZE);
  localparam int NGRP     = (SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic pick;
    logic commit;
    logic div_start;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pstc_div.sv -----
// Serial restoring divider: two lanes (x and y sums) share one step counter and divisor.
// Quotient truncated toward zero. Depends on pstc_pkg.
`default_nettype none

module pstc_div import pstc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [SUM_W-1:0]    dvd_x_i,
  input  wire logic signed [SUM_W-1:0]    dvd_y_i,
  input  wire logic        [CNT_W-1:0]    dvs_i,
  output logic                            done_o,
  output logic signed      [COORD_W-1:0]  quot_x_o,
  output logic signed      [COORD_W-1:0]  quot_y_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q  [2];
  logic [SUM_W-1:0]  quo_q  [2];
  logic [CNT_W-1:0]  rem_q  [2];

  logic [SUM_W-1:0]  mag    [2];
  logic              neg    [2];
  logic [CNT_W:0]    trial  [2];
  logic              ge     [2];
  logic [CNT_W-1:0]  rem_d  [2];
  logic [SUM_W-1:0]  quo_d  [2];
  logic [SUM_W-1:0]  signed_q [2];

  always_comb begin
    neg[0] = dvd_x_i[SUM_W-1];
    neg[1] = dvd_y_i[SUM_W-1];
    mag[0] = neg[0] ? (SUM_W'(0) - dvd_x_i) : dvd_x_i;
    mag[1] = neg[1] ? (SUM_W'(0) - dvd_y_i) : dvd_y_i;
    for (int l = 0; l < 2; l++) begin
      // shift in the next dividend bit, subtract when it fits
      trial[l]    = {rem_q[l], quo_q[l][SUM_W-1]};
      ge[l]       = trial[l] >= {1'b0, dvs_q};
      rem_d[l]    = ge[l] ? CNT_W'(trial[l] - {1'b0, dvs_q}) : CNT_W'(trial[l]);
      quo_d[l]    = {quo_q[l][SUM_W-2:0], ge[l]};
      signed_q[l] = neg_q[l] ? (SUM_W'(0) - quo_q[l]) : quo_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(SUM_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= dvs_i;
      for (int l = 0; l < 2; l++) begin
        neg_q[l] <= neg[l];
        quo_q[l] <= mag[l];
        rem_q[l] <= '0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        quo_q[l] <= quo_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
  end

  assign done_o   = done_q;
  assign quot_x_o = signed_q[0][COORD_W-1:0];
  assign quot_y_o = signed_q[1][COORD_W-1:0];

`ifndef SYNTH
  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done together");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == '0 && !start_i) |=> done_q)
    else $error("divider did not finish after last step");
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> (rem_q[0] < dvs_q && rem_q[1] < dvs_q))
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pstc_ctrl.sv -----
// Sequencing state machine: accept, free-slot search, commit, divide, present.
// Depends on pstc_pkg for command and status types.
`default_nettype none

module pstc_ctrl import pstc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_START  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_PICK;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_START;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pstc_datapath.sv -----
// Slot valid bits, coordinate memory, running sums, count, result and output registers.
// Instantiates pstc_div; depends on pstc_pkg.
`default_nettype none

module pstc_datapath import pstc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  output stat_t                           stat_o,
  input  wire logic                       op_i,
  input  wire logic signed [COORD_W-1:0]  point_x_i,
  input  wire logic signed [COORD_W-1:0]  point_y_i,
  input  wire logic        [IDX_W-1:0]    slot_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [1:0]          status_o,
  output logic             [IDX_W-1:0]    slot_used_o,
  output logic signed      [COORD_W-1:0]  out_x_o,
  output logic signed      [COORD_W-1:0]  out_y_o,
  output logic             [OCC_W-1:0]    occupied_count_o,
  output logic signed      [COORD_W-1:0]  centroid_x_o,
  output logic signed      [COORD_W-1:0]  centroid_y_o,
  output logic                            centroid_valid_o
);

  function automatic logic [GRP_W:0] first_free_grp(input logic [NGRP-1:0] f);
    logic [GRP_W:0] r;
    r = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (f[g]) r = {1'b1, GRP_W'(g)};
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] first_free_bit(input logic [GRP_SIZE-1:0] occ);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int b = GRP_SIZE - 1; b >= 0; b--) begin
      if (!occ[b]) r = BIT_W'(b);
    end
    return r;
  endfunction

  // Table state
  logic [SLOTS-1:0]              valid_q;
  logic [2*COORD_W-1:0]          mem_q [SLOTS];
  logic signed [SUM_W-1:0]       sum_x_q, sum_y_q;
  logic [CNT_W-1:0]              count_q;

  // Item registers
  logic                          op_q;
  logic signed [COORD_W-1:0]     px_q, py_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          in_range_q;
  logic [2*COORD_W-1:0]          rd_q;
  logic                          grp_found_q;
  logic [GRP_W-1:0]              grp_q;
  logic [SLOT_W-1:0]             slot_q;

  // Pending result
  status_e                       res_status_q;
  logic [IDX_W-1:0]              res_used_q;
  logic signed [COORD_W-1:0]     res_x_q, res_y_q;

  // Output register
  logic                          out_valid_q;
  status_e                       out_status_q;
  logic [IDX_W-1:0]              out_used_q;
  logic signed [COORD_W-1:0]     out_x_q, out_y_q;
  logic [OCC_W-1:0]              out_occ_q;
  logic signed [COORD_W-1:0]     out_cx_q, out_cy_q;
  logic                          out_cvalid_q;

  logic [NGRP*GRP_SIZE-1:0]      valid_pad;
  logic [GRP_SIZE-1:0]           grp_occ [NGRP];
  logic [NGRP-1:0]               grp_free;
  logic [GRP_W:0]                grp_sel;
  logic [SLOT_W-1:0]             rd_addr;
  logic signed [COORD_W-1:0]     rd_x, rd_y;
  logic                          ins_ok, ins_full, ext_hit;
  logic                          div_done;
  logic signed [COORD_W-1:0]     quot_x, quot_y;
  logic                          cnt_nz;

  // Slots past the end of the table read as occupied
  for (genvar i = 0; i < NGRP * GRP_SIZE; i++) begin : g_pad
    if (i < SLOTS) begin : g_in
      assign valid_pad[i] = valid_q[i];
    end else begin : g_out
      assign valid_pad[i] = 1'b1;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_occ[g]  = valid_pad[g*GRP_SIZE +: GRP_SIZE];
    assign grp_free[g] = ~&grp_occ[g];
  end

  assign grp_sel  = first_free_grp(grp_free);
  assign rd_addr  = SLOT_W'(idx_q);
  assign rd_x     = $signed(rd_q[2*COORD_W-1:COORD_W]);
  assign rd_y     = $signed(rd_q[COORD_W-1:0]);
  assign ins_ok   = (op_q == OP_INSERT) && grp_found_q;
  assign ins_full = (op_q == OP_INSERT) && !grp_found_q;
  assign ext_hit  = (op_q == OP_EXTRACT) && in_range_q && valid_q[rd_addr];
  assign cnt_nz   = count_q != '0;

  // Table state with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      if (ins_ok) begin
        valid_q[slot_q] <= 1'b1;
        sum_x_q         <= sum_x_q + SUM_W'(px_q);
        sum_y_q         <= sum_y_q + SUM_W'(py_q);
        count_q         <= count_q + 1'b1;
      end else if (ext_hit) begin
        valid_q[rd_addr] <= 1'b0;
        sum_x_q          <= sum_x_q - SUM_W'(rd_x);
        sum_y_q          <= sum_y_q - SUM_W'(rd_y);
        count_q          <= count_q - 1'b1;
      end
    end
  end

  // Coordinate memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ins_ok) mem_q[slot_q] <= {px_q, py_q};
    if (cmd_i.fetch)            rd_q <= mem_q[rd_addr];
  end

  // Item, search and pending result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= op_i;
      px_q       <= point_x_i;
      py_q       <= point_y_i;
      idx_q      <= slot_index_i;
      in_range_q <= 32'(slot_index_i) < 32'(SLOTS);
    end
    if (cmd_i.fetch) begin
      grp_found_q <= grp_sel[GRP_W];
      grp_q       <= grp_sel[GRP_W-1:0];
    end
    if (cmd_i.pick) begin
      slot_q <= SLOT_W'({grp_q, first_free_bit(grp_occ[grp_q])});
    end
    if (cmd_i.commit) begin
      if (op_q == OP_INSERT) begin
        res_status_q <= ins_full ? ST_FULL : ST_OK;
        res_used_q   <= ins_full ? '0 : IDX_W'(slot_q);
      end else begin
        res_status_q <= ext_hit ? ST_OK : ST_EMPTY;
        res_used_q   <= idx_q;
      end
      res_x_q <= ext_hit ? rd_x : '0;
      res_y_q <= ext_hit ? rd_y : '0;
    end
  end

  pstc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .dvd_x_i  (sum_x_q),
    .dvd_y_i  (sum_y_q),
    .dvs_i    (count_q),
    .done_o   (div_done),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           out_valid_q <= 1'b0;
    else if (cmd_i.load)   out_valid_q <= 1'b1;
    else if (out_ready_i)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_q <= res_status_q;
      out_used_q   <= res_used_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
      out_occ_q    <= OCC_W'(count_q);
      out_cx_q     <= cnt_nz ? quot_x : '0;
      out_cy_q     <= cnt_nz ? quot_y : '0;
      out_cvalid_q <= cnt_nz;
    end
  end

  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign slot_used_o      = out_used_q;
  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign occupied_count_o = out_occ_q;
  assign centroid_x_o     = out_cx_q;
  assign centroid_y_o     = out_cy_q;
  assign centroid_valid_o = out_cvalid_q;

`ifndef SYNTH
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("occupied count differs from number of valid slots");
  a_empty_sums_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_x_q == '0 && sum_y_q == '0))
    else $error("running sums not zero with an empty table");
  a_cvalid_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cvalid_q == (out_occ_q != '0)))
    else $error("centroid valid flag disagrees with occupied count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/point_slot_table_centroid_unit.sv -----
// Point slot table with running centroid: an accepted item passes the fetch, pick, commit,
// start, divide and load states, load waiting for a free output register; a new item is
// taken only after the last result is loaded. The serial divider makes one quotient bit per
// cycle over the 23-bit sums, with x and y in parallel lanes. Reset (rst_ni, asynchronous,
// active low) empties the table and zeroes sums and count at once; slot coordinates stay.
`default_nettype none

module point_slot_table_centroid_unit import pstc_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       op_i,
  input  wire logic signed [COORD_W-1:0]  point_x_i,
  input  wire logic signed [COORD_W-1:0]  point_y_i,
  input  wire logic        [IDX_W-1:0]    slot_index_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [1:0]          status_o,
  output logic             [IDX_W-1:0]    slot_used_o,
  output logic signed      [COORD_W-1:0]  out_x_o,
  output logic signed      [COORD_W-1:0]  out_y_o,
  output logic             [OCC_W-1:0]    occupied_count_o,
  output logic signed      [COORD_W-1:0]  centroid_x_o,
  output logic signed      [COORD_W-1:0]  centroid_y_o,
  output logic                            centroid_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  pstc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pstc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (op_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_used_o      (slot_used_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .occupied_count_o (occupied_count_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .centroid_valid_o (centroid_valid_o)
  );

endmodule

`default_nettype wire

// ----- tb/pstc_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for the point slot table unit: keeps its own copy of the slot table, the
// coordinate sums and the count, predicts one result per accepted item and compares in order.
// Depends on pstc_pkg for sizes, operation codes and status codes.

module pstc_table_checker import pstc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       op_i,
  input  logic signed [COORD_W-1:0]  point_x_i,
  input  logic signed [COORD_W-1:0]  point_y_i,
  input  logic        [IDX_W-1:0]    slot_index_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic        [1:0]          status_i,
  input  logic        [IDX_W-1:0]    slot_used_i,
  input  logic signed [COORD_W-1:0]  out_x_i,
  input  logic signed [COORD_W-1:0]  out_y_i,
  input  logic        [OCC_W-1:0]    occupied_count_i,
  input  logic signed [COORD_W-1:0]  centroid_x_i,
  input  logic signed [COORD_W-1:0]  centroid_y_i,
  input  logic                       centroid_valid_i,
  output int                         results_outstanding_o,
  output int                         mismatches_o
);

  typedef struct packed {
    status_e                    status;
    logic        [IDX_W-1:0]    slot;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic        [OCC_W-1:0]    occ;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic                       cvalid;
  } table_result_t;

  bit                        slot_live [SLOTS];
  logic signed [COORD_W-1:0] slot_px   [SLOTS];
  logic signed [COORD_W-1:0] slot_py   [SLOTS];
  logic signed [SUM_W-1:0]   acc_x;
  logic signed [SUM_W-1:0]   acc_y;
  logic        [CNT_W-1:0]   live_count;

  table_result_t pending_centroid_results [$];
  int            mismatch_n = 0;

  task automatic report_mismatch(string msg);
    mismatch_n++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic table_result_t advance_table(logic op, logic signed [COORD_W-1:0] px,
                                                  logic signed [COORD_W-1:0] py,
                                                  logic [IDX_W-1:0] idx);
    table_result_t r;
    int            k;
    bit            placed;
    r = '0;
    r.status = ST_OK;
    placed = 1'b0;
    if (op == OP_INSERT) begin
      for (k = 0; k < SLOTS; k++) begin
        if (!placed && !slot_live[k]) begin
          placed = 1'b1;
          slot_live[k] = 1'b1;
          slot_px[k] = px;
          slot_py[k] = py;
          acc_x += px;
          acc_y += py;
          live_count++;
          r.slot = IDX_W'(k);
        end
      end
      if (!placed) r.status = ST_FULL;
    end else begin
      r.slot = idx;
      if (int'(idx) < SLOTS && slot_live[idx]) begin
        r.px = slot_px[idx];
        r.py = slot_py[idx];
        acc_x -= slot_px[idx];
        acc_y -= slot_py[idx];
        live_count--;
        slot_live[idx] = 1'b0;
      end else begin
        r.status = ST_EMPTY;
      end
    end
    r.occ = OCC_W'(live_count);
    // integer division truncates toward zero, as the centroid requires
    if (live_count != 0) begin
      r.cx = COORD_W'(int'(acc_x) / int'(live_count));
      r.cy = COORD_W'(int'(acc_y) / int'(live_count));
      r.cvalid = 1'b1;
    end
    return r;
  endfunction

  task automatic check_result(table_result_t want);
    if (status_i !== want.status)
      report_mismatch($sformatf("status got %0d expected %0d", status_i, want.status));
    if (slot_used_i !== want.slot)
      report_mismatch($sformatf("slot_used got %0d expected %0d", slot_used_i, want.slot));
    if (out_x_i !== want.px)
      report_mismatch($sformatf("out_x got %0d expected %0d", out_x_i, want.px));
    if (out_y_i !== want.py)
      report_mismatch($sformatf("out_y got %0d expected %0d", out_y_i, want.py));
    if (occupied_count_i !== want.occ)
      report_mismatch($sformatf("occupied_count got %0d expected %0d",
                                occupied_count_i, want.occ));
    if (centroid_x_i !== want.cx)
      report_mismatch($sformatf("centroid_x got %0d expected %0d", centroid_x_i, want.cx));
    if (centroid_y_i !== want.cy)
      report_mismatch($sformatf("centroid_y got %0d expected %0d", centroid_y_i, want.cy));
    if (centroid_valid_i !== want.cvalid)
      report_mismatch($sformatf("centroid_valid got %0d expected %0d",
                                centroid_valid_i, want.cvalid));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_live[k] = 1'b0;
        slot_px[k] = '0;
        slot_py[k] = '0;
      end
      acc_x = '0;
      acc_y = '0;
      live_count = '0;
      pending_centroid_results.delete();
      results_outstanding_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_centroid_results.size() == 0)
          report_mismatch($sformatf("result with no item pending, slot_used %0d",
                                    slot_used_i));
        else
          check_result(pending_centroid_results.pop_front());
      end
      if (in_valid_i && in_ready_i)
        pending_centroid_results.push_back(advance_table(op_i, point_x_i, point_y_i,
                                                         slot_index_i));
      results_outstanding_o <= pending_centroid_results.size();
      mismatches_o <= mismatch_n;
    end
  end

endmodule

// ----- tb/tb_point_slot_table_centroid_unit.sv -----
`timescale 1ns / 100ps
// Top of the point slot table testbench: clock, reset, item stimulus and result draining.
// Depends on pstc_pkg, point_slot_table_centroid_unit and pstc_table_checker.

module tb_point_slot_table_centroid_unit;
  import pstc_pkg::*;

  localparam int ITEM_TARGET = 1970;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       op_i = OP_INSERT;
  logic signed [COORD_W-1:0]  point_x_i = '0;
  logic signed [COORD_W-1:0]  point_y_i = '0;
  logic        [IDX_W-1:0]    slot_index_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic        [1:0]          status_o;
  logic        [IDX_W-1:0]    slot_used_o;
  logic signed [COORD_W-1:0]  out_x_o;
  logic signed [COORD_W-1:0]  out_y_o;
  logic        [OCC_W-1:0]    occupied_count_o;
  logic signed [COORD_W-1:0]  centroid_x_o;
  logic signed [COORD_W-1:0]  centroid_y_o;
  logic                       centroid_valid_o;

  int results_outstanding;
  int mismatch_count;

  // occupancy as seen from the stimulus side, used only to pick slots worth extracting
  bit held [SLOTS];
  int held_n = 0;
  int items_sent = 0;
  bit sender_gapless = 1'b0;

  point_slot_table_centroid_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .slot_index_i     (slot_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_used_o      (slot_used_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .occupied_count_o (occupied_count_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .centroid_valid_o (centroid_valid_o)
  );

  pstc_table_checker u_table_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_i            (in_ready_o),
    .op_i                  (op_i),
    .point_x_i             (point_x_i),
    .point_y_i             (point_y_i),
    .slot_index_i          (slot_index_i),
    .out_valid_i           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .status_i              (status_o),
    .slot_used_i           (slot_used_o),
    .out_x_i               (out_x_o),
    .out_y_i               (out_y_o),
    .occupied_count_i      (occupied_count_o),
    .centroid_x_i          (centroid_x_o),
    .centroid_y_i          (centroid_y_o),
    .centroid_valid_i      (centroid_valid_o),
    .results_outstanding_o (results_outstanding),
    .mismatches_o          (mismatch_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic signed [COORD_W-1:0] draw_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = C_MAX;
      1: v = C_MIN;
      2: v = COORD_W'($urandom_range(0, 16)) - COORD_W'(8);
      default: v = COORD_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_held();
    int                start;
    int                k;
    bit                found;
    logic [IDX_W-1:0]  pick;
    start = $urandom_range(0, SLOTS - 1);
    pick = IDX_W'(start);
    found = 1'b0;
    for (k = 0; k < SLOTS; k++) begin
      if (!found && held[(start + k) % SLOTS]) begin
        found = 1'b1;
        pick = IDX_W'((start + k) % SLOTS);
      end
    end
    return pick;
  endfunction

  task automatic drive_item(logic op, logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py, logic [IDX_W-1:0] idx);
    int gap;
    gap = sender_gapless ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    point_x_i <= px;
    point_y_i <= py;
    slot_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic issue_insert(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
    int  k;
    bit  placed;
    placed = 1'b0;
    for (k = 0; k < SLOTS; k++) begin
      if (!placed && !held[k]) begin
        placed = 1'b1;
        held[k] = 1'b1;
        held_n++;
      end
    end
    drive_item(OP_INSERT, px, py, IDX_W'($urandom));
  endtask

  task automatic issue_extract(logic [IDX_W-1:0] idx);
    if (held[idx]) begin
      held[idx] = 1'b0;
      held_n--;
    end
    drive_item(OP_EXTRACT, COORD_W'($urandom), COORD_W'($urandom), idx);
  endtask

  initial begin
    int  mode;
    int  run;
    int  k;
    bit  first;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then extremes, truncation toward zero on negative sums, refill of a hole
    issue_extract(IDX_W'(0));
    issue_extract(IDX_W'(SLOTS - 1));
    issue_insert(C_MAX, C_MIN);
    issue_insert(C_MIN, C_MAX);
    issue_insert(-COORD_W'(1), -COORD_W'(2));
    issue_insert(C_MAX, C_MAX);
    issue_extract(IDX_W'(1));
    issue_extract(IDX_W'(1));
    issue_insert('0, '0);
    issue_insert(C_MIN, C_MIN);
    issue_insert(COORD_W'(1), -COORD_W'(1));
    issue_extract(IDX_W'(SLOTS - 1));
    for (k = 0; k < 6; k++) issue_extract(IDX_W'(k));
    issue_extract(IDX_W'(3));

    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      // open with a fill so the full table is reached early
      mode = first ? 0 : $urandom_range(0, 9);
      first = 1'b0;
      sender_gapless = ($urandom_range(0, 3) == 0);
      if (mode <= 2) begin
        while (held_n < SLOTS) issue_insert(draw_coord(), draw_coord());
        run = $urandom_range(1, 4);
        repeat (run) issue_insert(draw_coord(), draw_coord());
      end else if (mode <= 5) begin
        while (held_n > 0) issue_extract(pick_held());
        issue_extract(IDX_W'($urandom));
      end else begin
        run = $urandom_range(20, 60);
        repeat (run) begin
          if ($urandom_range(0, 1) == 0)
            issue_insert(draw_coord(), draw_coord());
          else if (held_n > 0 && $urandom_range(0, 3) != 0)
            issue_extract(pick_held());
          else
            issue_extract(IDX_W'($urandom));
        end
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    for (k = 0; k < 20000 && results_outstanding != 0; k++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && results_outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall per item, calm stretches, and two long hold-offs
  initial begin
    int wait_n;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_n = calm ? 0 : $urandom_range(0, 8);
      // hold long enough for the unit to back up and drop in_ready
      if (taken == 150 || taken == 900) wait_n = 400;
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pstc_pkg.sv
rtl/core/pstc_div.sv
rtl/core/pstc_ctrl.sv
rtl/core/pstc_datapath.sv
rtl/core/point_slot_table_centroid_unit.sv
tb/pstc_table_checker.sv
tb/tb_point_slot_table_centroid_unit.sv
